@@ rtl/rmh_pkg.sv @@
// ----------------------------------------------------------------------------
// rmh_pkg: shared types, constants and sine table functions
// Holds the step control tag, field widths, register indexes and the integer
// series that builds the Q1.15 sine table at elaboration.
// ----------------------------------------------------------------------------
package rmh_pkg;

   localparam int COORD_W   = 32;
   localparam int PHASE_W   = 16;
   localparam int STEPS_W   = 11;
   localparam int SINE_W    = 16;
   localparam int PROD_W    = COORD_W + SINE_W;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_ANGLE      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_ROUND = 1'b1;

   // Tag that travels with every rotation step through the datapath.
   typedef struct packed {
      logic first;   // first step of a point: the running minimum restarts
      logic last;    // last step of a point: the result is written out
      logic use_h;   // the rotated height takes part in the minimum
   } rmh_ctl_type;

   // Sine of a first-quadrant phase r in [0, 16384], Q1.15, from a Taylor
   // series in Q30. Used only to build constant tables.
   function automatic longint quarter_sine(input longint r);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      x    = (64'(r) * 64'd6746518852) >> 16;
      x2   = (x * x) >> 30;
      term = x;
      sum  = 0;
      for (int n = 1; n <= 8; n++) begin
         if ((n & 1) != 0) begin
            sum = sum + longint'(term);
         end else begin
            sum = sum - longint'(term);
         end
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      end
      if (sum < 0) begin
         sum = 0;
      end
      sum = (sum + 16384) >>> 15;
      if (sum > 32767) begin
         sum = 32767;
      end
      return sum;
   endfunction

   // Full-turn sine of a 16-bit phase by quadrant symmetry.
   function automatic logic signed [SINE_W-1:0] full_sine(input logic [PHASE_W-1:0] ph);
      longint s;
      if (ph[14]) begin
         s = quarter_sine(16384 - longint'(ph[13:0]));
      end else begin
         s = quarter_sine(longint'(ph[13:0]));
      end
      if (ph[15]) begin
         s = -s;
      end
      return SINE_W'(s);
   endfunction

endpackage

@@ rtl/rmh_sine_rom.sv @@
// ----------------------------------------------------------------------------
// rmh_sine_rom: constant sine table with a registered read port
// Entry k holds the Q1.15 sine of phase floor(k * 65536 / DEPTH).
// ----------------------------------------------------------------------------
module rmh_sine_rom
   import rmh_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic signed [SINE_W-1:0]       rd_data
);

   logic signed [SINE_W-1:0] tab [DEPTH];
   logic signed [SINE_W-1:0] rd_data_ff;

   for (genvar k = 0; k < DEPTH; k++) begin : g_tab
      localparam logic [PHASE_W-1:0] PH = PHASE_W'((64'(k) * 64'd65536) / 64'(DEPTH));
      localparam logic signed [SINE_W-1:0] VAL = full_sine(PH);
      assign tab[k] = VAL;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= tab[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rmh_seq.sv @@
// ----------------------------------------------------------------------------
// rmh_seq: step sequencer
// Holds one point and issues its rotation steps, one per cycle while adv is high, each with
// the running phase and a control tag.
// ----------------------------------------------------------------------------
module rmh_seq
   import rmh_pkg::*;
#(
   parameter int MAX_STEPS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [COORD_W-1:0]  req_y,
   input  logic signed [COORD_W-1:0]  req_z,
   input  logic [PHASE_W-1:0]         step_angle,
   input  logic [STEPS_W-1:0]         steps_cfg,
   output logic                       tok_valid,
   output rmh_ctl_type                tok_ctl,
   output logic [PHASE_W-1:0]         tok_phase,
   output logic signed [COORD_W-1:0]  tok_y,
   output logic signed [COORD_W-1:0]  tok_z
);

   localparam int CNT_W = $clog2(MAX_STEPS + 1);

   logic                      busy_ff;
   logic                      first_ff;
   logic                      zero_ff;
   logic [CNT_W-1:0]          remain_ff;
   logic [PHASE_W-1:0]        phase_ff;
   logic signed [COORD_W-1:0] y_ff;
   logic signed [COORD_W-1:0] z_ff;
   logic [CNT_W-1:0]          steps_in;
   logic                      tok_last;
   logic                      take;

   // Step counts beyond the supported maximum are clamped.
   always_comb begin
      if (32'(steps_cfg) > 32'(MAX_STEPS)) begin
         steps_in = CNT_W'(MAX_STEPS);
      end else begin
         steps_in = CNT_W'(steps_cfg);
      end
   end

   assign tok_last  = zero_ff || (remain_ff == CNT_W'(1));
   assign req_ready = adv && (!busy_ff || tok_last);
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         first_ff  <= 1'b0;
         zero_ff   <= 1'b0;
         remain_ff <= '0;
      end else if (take) begin
         busy_ff   <= 1'b1;
         first_ff  <= 1'b1;
         zero_ff   <= (steps_in == '0);
         remain_ff <= steps_in;
      end else if (adv && busy_ff) begin
         busy_ff   <= !tok_last;
         first_ff  <= 1'b0;
         remain_ff <= remain_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         y_ff     <= req_y;
         z_ff     <= req_z;
         phase_ff <= step_angle;
      end else if (adv && busy_ff) begin
         phase_ff <= phase_ff + step_angle;
      end
   end

   assign tok_valid     = busy_ff;
   assign tok_ctl.first = first_ff;
   assign tok_ctl.last  = tok_last;
   assign tok_ctl.use_h = !zero_ff;
   assign tok_phase     = phase_ff;
   assign tok_y         = y_ff;
   assign tok_z         = z_ff;

endmodule

@@ rtl/rmh_rot_pipe.sv @@
// ----------------------------------------------------------------------------
// rmh_rot_pipe: four-stage rotated height datapath
// Table index, sine and cosine read, the two products, then shift,
// subtract and saturate. The whole pipe moves on adv.
// ----------------------------------------------------------------------------
module rmh_rot_pipe
   import rmh_pkg::*;
#(
   parameter int TRIG_TABLE_DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  rmh_ctl_type                in_ctl,
   input  logic [PHASE_W-1:0]         in_phase,
   input  logic signed [COORD_W-1:0]  in_y,
   input  logic signed [COORD_W-1:0]  in_z,
   output logic                       out_valid,
   output rmh_ctl_type                out_ctl,
   output logic signed [COORD_W-1:0]  out_y,
   output logic signed [COORD_W-1:0]  out_h
);

   localparam int IDX_W = $clog2(TRIG_TABLE_DEPTH);

   logic [PHASE_W-1:0]        cos_phase;
   logic [31:0]               sin_scaled;
   logic [31:0]               cos_scaled;

   logic                      v1_ff, v2_ff, v3_ff, v4_ff;
   rmh_ctl_type               c1_ff, c2_ff, c3_ff, c4_ff;
   logic signed [COORD_W-1:0] y1_ff, y2_ff, y3_ff, y4_ff;
   logic signed [COORD_W-1:0] z1_ff, z2_ff;
   logic [IDX_W-1:0]          sin_idx_ff, cos_idx_ff;
   logic signed [SINE_W-1:0]  sin_val, cos_val;
   logic signed [PROD_W-1:0]  p_yc_ff, p_zs_ff;
   logic signed [COORD_W-1:0] h4_ff;

   logic signed [PROD_W-16:0] yc_sh, zs_sh;
   logic signed [PROD_W-14:0] diff;
   logic signed [COORD_W-1:0] h_in;

   // Stage 1: phase to table index, floor(ph * DEPTH / 65536).
   assign cos_phase  = in_phase + QUARTER_TURN;
   assign sin_scaled = 32'(in_phase) * 32'(TRIG_TABLE_DEPTH);
   assign cos_scaled = 32'(cos_phase) * 32'(TRIG_TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (adv) begin
         sin_idx_ff <= sin_scaled[IDX_W+15:16];
         cos_idx_ff <= cos_scaled[IDX_W+15:16];
         c1_ff      <= in_ctl;
         y1_ff      <= in_y;
         z1_ff      <= in_z;
      end
   end

   // Stage 2: table reads.
   rmh_sine_rom #(.DEPTH(TRIG_TABLE_DEPTH)) u_sin_rom (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr (sin_idx_ff),
      .rd_data (sin_val)
   );

   rmh_sine_rom #(.DEPTH(TRIG_TABLE_DEPTH)) u_cos_rom (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr (cos_idx_ff),
      .rd_data (cos_val)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         c2_ff <= c1_ff;
         y2_ff <= y1_ff;
         z2_ff <= z1_ff;
      end
   end

   // Stage 3: the two products.
   always_ff @(posedge clock) begin
      if (adv) begin
         p_yc_ff <= y2_ff * cos_val;
         p_zs_ff <= z2_ff * sin_val;
         c3_ff   <= c2_ff;
         y3_ff   <= y2_ff;
      end
   end

   // Stage 4: floor shift by 15, difference, saturation to 32 bits.
   assign yc_sh = p_yc_ff[PROD_W-1:15];
   assign zs_sh = p_zs_ff[PROD_W-1:15];
   assign diff  = {{2{yc_sh[PROD_W-16]}}, yc_sh} - {{2{zs_sh[PROD_W-16]}}, zs_sh};

   always_comb begin
      if (diff[PROD_W-14:COORD_W-1] == '0 || diff[PROD_W-14:COORD_W-1] == '1) begin
         h_in = diff[COORD_W-1:0];
      end else if (diff[PROD_W-14]) begin
         h_in = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         h_in = {1'b0, {(COORD_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h4_ff <= h_in;
         c4_ff <= c3_ff;
         y4_ff <= y3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_ctl   = c4_ff;
   assign out_y     = y4_ff;
   assign out_h     = h4_ff;

endmodule

@@ rtl/rotated_min_height.sv @@
// ----------------------------------------------------------------------------
// rotated_min_height: least height of a point swept around the lathe axis
//
// A point word (y, z in signed Q16.16) enters on the req_ stream. The block
// rotates it by i * step_angle for i = 1 .. steps_per_round (clamped to
// MAX_STEPS) and returns on the rsp_ stream one word: the least of y and
// all rotated heights y*cos - z*sin, saturated to 32 bits.
// A point holds the step sequencer for as many steps as its clamped step
// count, at least one; the sequencer feeds one step per cycle, unless
// stalled, into one shared datapath with two table reads and two multipliers.
// The next point is taken in the cycle its predecessor issues its last step.
// Configuration must be written through csr_ only while the block is idle;
// the block itself does not enforce this.
// Reset clears both configuration registers, the sequencer and all valid
// bits; the sine table is constant and needs no fill after reset.
// When the receiver stalls with a result word waiting, the whole pipe and
// the sequencer freeze and req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rotated_min_height
   import rmh_pkg::*;
#(
   parameter int MAX_STEPS        = 1024,
   parameter int TRIG_TABLE_DEPTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   // Point words.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [2*COORD_W-1:0]   req_tdata,   // y_coord [31:0], z_coord [63:32]
   // Result words.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [COORD_W-1:0]     rsp_tdata,   // min_height [31:0]
   // Configuration writes.
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_addr,
   input  logic [CSR_DAT_W-1:0]   csr_wdata
);

   logic [PHASE_W-1:0]        step_angle_ff;
   logic [STEPS_W-1:0]        steps_ff;

   logic                      adv;
   logic                      tok_valid;
   rmh_ctl_type               tok_ctl;
   logic [PHASE_W-1:0]        tok_phase;
   logic signed [COORD_W-1:0] tok_y, tok_z;

   logic                      s4_valid;
   rmh_ctl_type               s4_ctl;
   logic signed [COORD_W-1:0] s4_y, s4_h;

   logic signed [COORD_W-1:0] best_ff;
   logic signed [COORD_W-1:0] base;
   logic signed [COORD_W-1:0] best_in;
   logic                      out_valid_ff;
   logic [COORD_W-1:0]        out_data_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_angle_ff <= '0;
         steps_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_STEP_ANGLE:      step_angle_ff <= csr_wdata[PHASE_W-1:0];
            CSR_STEPS_PER_ROUND: steps_ff      <= csr_wdata[STEPS_W-1:0];
            default: ;
         endcase
      end
   end

   // Everything moves unless a result word is waiting and not taken.
   assign adv = !out_valid_ff || rsp_tready;

   rmh_seq #(.MAX_STEPS(MAX_STEPS)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_y      (req_tdata[COORD_W-1:0]),
      .req_z      (req_tdata[2*COORD_W-1:COORD_W]),
      .step_angle (step_angle_ff),
      .steps_cfg  (steps_ff),
      .tok_valid  (tok_valid),
      .tok_ctl    (tok_ctl),
      .tok_phase  (tok_phase),
      .tok_y      (tok_y),
      .tok_z      (tok_z)
   );

   rmh_rot_pipe #(.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (tok_valid),
      .in_ctl    (tok_ctl),
      .in_phase  (tok_phase),
      .in_y      (tok_y),
      .in_z      (tok_z),
      .out_valid (s4_valid),
      .out_ctl   (s4_ctl),
      .out_y     (s4_y),
      .out_h     (s4_h)
   );

   // Running minimum: the first step of a point restarts from its own y.
   // A point with no steps carries a single step whose height is ignored.
   always_comb begin
      base = s4_ctl.first ? s4_y : best_ff;
      if (s4_ctl.use_h && (s4_h < base)) begin
         best_in = s4_h;
      end else begin
         best_in = base;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s4_valid) begin
         best_ff <= best_in;
         if (s4_ctl.last) begin
            out_data_ff <= best_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv && s4_valid && s4_ctl.last) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // After a point's last step leaves the sequencer, the next step issued
   // belongs to a new point.
   a_seq_restart: assert property (@(posedge clock) disable iff (reset)
      tok_valid && tok_ctl.last && adv |=> !tok_valid || tok_ctl.first)
      else $error("step after a last step does not start a new point");

   // A step without a height only occurs for points with no steps.
   a_empty_point: assert property (@(posedge clock) disable iff (reset)
      tok_valid && !tok_ctl.use_h |-> tok_ctl.first && tok_ctl.last)
      else $error("height-free step inside a multi-step point");

   // The result never exceeds the start height of its point.
   a_min_bound: assert property (@(posedge clock) disable iff (reset)
      s4_valid && s4_ctl.last && adv |=> $signed(rsp_tdata) <= $past(s4_y))
      else $error("result above the start height");

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rotated_min_height
// Point words go in on the req_ stream from a queue that the main initial
// block fills, one configuration phase at a time. Every accepted point is run
// through a local fixed-point sweep that gives the expected least height. The
// monitor compares each result word on the rsp_ stream against the oldest
// expected height. Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
   import rmh_pkg::*;

   localparam int MAX_STEPS        = 1024;
   localparam int TRIG_TABLE_DEPTH = 1024;
   localparam int CYCLE_LIMIT      = 500000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int RANDOM_PHASES    = 12;

   localparam logic signed [31:0] COORD_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] COORD_MIN = 32'sh80000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [2*COORD_W-1:0]   req_tdata = '0;   // y_coord [31:0], z_coord [63:32]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [COORD_W-1:0]     rsp_tdata;        // min_height [31:0]
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_addr = '0;
   logic [CSR_DAT_W-1:0]   csr_wdata = '0;

   // Local copy of the configuration, updated whenever the bench writes it.
   logic [PHASE_W-1:0]     sweep_angle = '0;
   logic [STEPS_W-1:0]     sweep_steps = '0;

   // Q1.15 sine table, filled at time zero the same way the block builds its own.
   logic signed [SINE_W-1:0] sine_lut [TRIG_TABLE_DEPTH];

   logic [2*COORD_W-1:0]     point_queue[$];       // points waiting to be sent
   logic signed [31:0]       expected_heights[$];  // least heights still owed
   logic signed [31:0]       want_height;

   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int failures       = 0;
   int cycle_count    = 0;

   rotated_min_height #(
      .MAX_STEPS        (MAX_STEPS),
      .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Sine of a first-quadrant phase (0 .. 16384) in Q1.15. The angle is turned
   // into Q30 radians and an eight-term Taylor series is summed with unsigned
   // 64-bit intermediates, then rounded to 15 fraction bits.
   function automatic int taylor_sin_q15(input int unsigned r);
      logic [63:0] rad;
      logic [63:0] rad_sq;
      logic [63:0] term;
      longint      acc;
      rad    = (64'(r) * 64'd6746518852) >> 16;
      rad_sq = (rad * rad) >> 30;
      term   = rad;
      acc    = 0;
      for (int k = 1; k <= 8; k++) begin
         if (k % 2 == 1) begin
            acc += longint'(term);
         end else begin
            acc -= longint'(term);
         end
         term = ((term * rad_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
      end
      if (acc < 0) begin
         acc = 0;
      end
      acc = (acc + 16384) >>> 15;
      if (acc > 32767) begin
         acc = 32767;
      end
      return int'(acc);
   endfunction

   function automatic logic signed [SINE_W-1:0] sine_at(input logic [PHASE_W-1:0] ph);
      int unsigned slot;
      slot = (int'(ph) * TRIG_TABLE_DEPTH) >> 16;
      if (slot >= TRIG_TABLE_DEPTH) begin
         slot = TRIG_TABLE_DEPTH - 1;
      end
      return sine_lut[slot];
   endfunction

   // Least height of one point over the start height and every rotation step
   // under the current configuration. Each product keeps the floor of its
   // value over 2^15, which an arithmetic shift of a signed longint gives.
   function automatic logic signed [31:0] lowest_height(input logic signed [31:0] y,
                                                        input logic signed [31:0] z);
      logic signed [31:0] low;
      logic [PHASE_W-1:0] ph;
      logic [PHASE_W-1:0] cos_ph;
      longint             h;
      int                 n;
      low = y;
      n   = (int'(sweep_steps) > MAX_STEPS) ? MAX_STEPS : int'(sweep_steps);
      for (int i = 1; i <= n; i++) begin
         ph     = PHASE_W'(i * int'(sweep_angle));
         cos_ph = ph + QUARTER_TURN;
         h = ((longint'(y) * sine_at(cos_ph)) >>> 15) - ((longint'(z) * sine_at(ph)) >>> 15);
         if (h > longint'(COORD_MAX)) begin
            h = longint'(COORD_MAX);
         end else if (h < longint'(COORD_MIN)) begin
            h = longint'(COORD_MIN);
         end
         if (h < longint'(low)) begin
            low = 32'(h);
         end
      end
      return low;
   endfunction

   // Coordinates: half full-range random words, a share of small values near
   // the origin, the corners of the signed range and words just inside them.
   function automatic logic [31:0] random_coord();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
         return $urandom;
      end else if (pick < 78) begin
         return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      end else if (pick < 90) begin
         case ($urandom_range(4))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return 32'sd1;
         endcase
      end
      return COORD_MAX - 32'($urandom_range(0, 1 << 16)) ^ {32{1'($urandom_range(1))}};
   endfunction

   task automatic add_point(input logic [31:0] y, input logic [31:0] z);
      point_queue.push_back({z, y});
   endtask

   // Wait until every queued point has gone in and every result has come out,
   // then let the pipeline settle before the next register write.
   task automatic wait_drained();
      while (point_queue.size() != 0 || req_tvalid || expected_heights.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers are written back to back, one per clock edge.
   task automatic set_sweep(input logic [PHASE_W-1:0] angle, input logic [STEPS_W-1:0] steps);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_STEP_ANGLE;
      csr_wdata <= CSR_DAT_W'(angle);
      @(posedge clock);
      csr_addr  <= CSR_STEPS_PER_ROUND;
      csr_wdata <= CSR_DAT_W'(steps);
      @(posedge clock);
      csr_we      <= 1'b0;
      sweep_angle  = angle;
      sweep_steps  = steps;
   endtask

   // Driver: a new point is offered only when the previous one was taken or
   // none was offered. The point taken at this edge is predicted right away,
   // since the configuration only changes while the block is drained.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            expected_heights.push_back(lowest_height(req_tdata[31:0], req_tdata[63:32]));
         end
         if (point_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_tdata  <= point_queue.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: checks each accepted result word against the oldest expected
   // height and stalls the result stream at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_heights.size() == 0) begin
               $error("min_height: unexpected word, actual %0d", $signed(rsp_tdata));
               failures++;
            end else begin
               want_height = expected_heights.pop_front();
               if (rsp_tdata !== want_height) begin
                  $error("min_height: expected %0d, actual %0d",
                         want_height, $signed(rsp_tdata));
                  failures++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [PHASE_W-1:0] angle;
      logic [STEPS_W-1:0] steps;
      logic [PHASE_W-1:0] ph;
      int                 s;
      int                 count;

      // Build the sine table by quadrant symmetry of the first-quadrant series.
      for (int k = 0; k < TRIG_TABLE_DEPTH; k++) begin
         ph = PHASE_W'((longint'(k) * 65536) / TRIG_TABLE_DEPTH);
         if (ph[14]) begin
            s = taylor_sin_q15(16384 - int'(ph[13:0]));
         end else begin
            s = taylor_sin_q15(int'(ph[13:0]));
         end
         sine_lut[k] = SINE_W'(ph[15] ? -s : s);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the sender idling lightly and the receiver heavily.
      send_gap_pct   = 17;
      recv_stall_pct = 52;

      // Eighth-turn steps: corners of both coordinates, which drive the
      // rotated height into saturation at both ends of the signed range.
      set_sweep(16'h2000, 11'd8);
      add_point(32'sd0, 32'sd0);
      add_point(COORD_MAX, COORD_MAX);
      add_point(COORD_MIN, COORD_MIN);
      add_point(COORD_MAX, COORD_MIN);
      add_point(COORD_MIN, COORD_MAX);
      add_point(COORD_MIN, 32'sd0);
      add_point(32'sd0, COORD_MIN);
      add_point(-32'sd1, -32'sd1);
      add_point(32'sd1, 32'sd1);
      add_point(32'sd65536, 32'sd0);
      add_point(32'sd0, -32'sd65536);
      add_point(32'h7FFF0000, 32'h80010000);
      wait_drained();

      // With no steps the start height comes back untouched.
      set_sweep(16'h0000, 11'd0);
      add_point(COORD_MAX, COORD_MIN);
      add_point(COORD_MIN, COORD_MAX);
      add_point(-32'sd1, 32'sd0);
      wait_drained();

      // A step count beyond the limit is cut down to the limit.
      set_sweep(16'hFFFF, 11'd2047);
      add_point(COORD_MAX, 32'sd0);
      add_point(COORD_MIN, COORD_MIN);
      add_point(32'sd65536, 32'sd65536);
      wait_drained();

      // Step angles past half a turn make the accumulated phase wrap often.
      set_sweep(16'h9000, 11'd1024);
      add_point(32'sd65536, -32'sd65536);
      add_point(COORD_MAX, COORD_MAX);
      wait_drained();

      // A single quarter-turn step: the height becomes close to -z, as the sine entry there is 32767 in Q1.15.
      set_sweep(16'h4000, 11'd1);
      add_point(32'sd65536, -32'sd65536);
      add_point(COORD_MIN, COORD_MIN);
      wait_drained();

      // Random part: one configuration per phase. The first third keeps the
      // directed idling, the second swaps the two sides, the last runs flat out.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < RANDOM_PHASES / 3) begin
            send_gap_pct   = 17;
            recv_stall_pct = 52;
         end else if (p < 2 * RANDOM_PHASES / 3) begin
            send_gap_pct   = 52;
            recv_stall_pct = 17;
         end else begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
         case ($urandom_range(5))
            0:       angle = 16'h0000;
            1:       angle = 16'hFFFF;
            default: angle = PHASE_W'($urandom);
         endcase
         // Two phases use the longest sweeps with only a few points, the rest
         // keep the step count short so the run stays quick.
         if (p == 3) begin
            steps = 11'd1024;
            count = 4;
         end else if (p == 9) begin
            steps = 11'd2047;
            count = 4;
         end else begin
            steps = ($urandom_range(9) == 0) ? 11'd0 : STEPS_W'($urandom_range(1, 48));
            count = 55;
         end
         set_sweep(angle, steps);
         repeat (count) add_point(random_coord(), random_coord());
         wait_drained();
      end

      // Nothing is owed any more; watch a full sweep length for stray words.
      repeat (MAX_STEPS + 8) @(posedge clock);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
